// ----- rtl/core/instruction_patch_table_defines.svh -----
// ----------------------------------------------------------------------------
// Instruction patch table assertion macros
// Shared concurrent assertion forms for the patch table RTL.
// ----------------------------------------------------------------------------
`ifndef INSTRUCTION_PATCH_TABLE_DEFINES_SVH
`define INSTRUCTION_PATCH_TABLE_DEFINES_SVH

// The condition must never hold outside reset.
`define IPT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define IPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ipt_pkg.sv -----
// ----------------------------------------------------------------------------
// Instruction patch table package
// Constants, codes and shared types of the patch table.
// ----------------------------------------------------------------------------
package ipt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [31:0] WORD_NOP = 32'hD503201F;
  localparam logic [31:0] WORD_B = 32'h14000000;
  localparam logic [31:0] OPC_MASK = 32'hFC000000;
  localparam logic [25:0] IMM26_MASK = 26'h3FFFFFF;

  typedef enum logic [2:0] {
    FUNC_APPLY_WORD = 3'd0,
    FUNC_APPLY_BRANCH = 3'd1,
    FUNC_APPLY_NOP = 3'd2,
    FUNC_REVERT = 3'd3,
    FUNC_REVERT_ALL = 3'd4,
    FUNC_STATS = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    STAT_OK = 3'd0,
    STAT_DISABLED = 3'd1,
    STAT_BAD_ADDR = 3'd2,
    STAT_DUPLICATE = 3'd3,
    STAT_FULL = 3'd4,
    STAT_RANGE = 3'd5,
    STAT_NOT_FOUND = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CFG_ENABLED = 2'd0,
    CFG_BASE = 2'd1,
    CFG_SIZE = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [31:0] original;
    logic [31:0] patched;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic head_clr;
    logic load;
    logic [IDX_W-1:0] load_idx;
    entry_t load_entry;
  } chain_ctrl_t;

endpackage

// ----- rtl/core/ipt_cell.sv -----
// ----------------------------------------------------------------------------
// Patch table cell
// Holds one table entry and its active mark; takes a new value when enabled.
// ----------------------------------------------------------------------------
module ipt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  ipt_pkg::entry_t din,
  input  logic            din_act,
  output ipt_pkg::entry_t dout,
  output logic            act
);
  import ipt_pkg::*;

  entry_t data_r;
  logic act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else if (take) begin
      act_r <= din_act;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= din;
    end
  end

  assign dout = data_r;
  assign act = act_r;

endmodule

// ----- rtl/core/ipt_chain.sv -----
// ----------------------------------------------------------------------------
// Patch table chain
// A ring of cells rotating one entry per cycle past the head cell on shift.
// ----------------------------------------------------------------------------
module ipt_chain (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ipt_pkg::chain_ctrl_t ctrl,
  output ipt_pkg::entry_t      head,
  output logic                 head_act
);
  import ipt_pkg::*;

  entry_t q [TABLE_ENTRIES];
  logic q_act [TABLE_ENTRIES];

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic sel;
    logic take;
    entry_t nb;
    logic nb_act;
    entry_t din;
    logic din_act;

    assign sel = ctrl.load && (ctrl.load_idx == IDX_W'(i));
    assign take = ctrl.shift || sel;

    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign nb = q[0];
      assign nb_act = q_act[0] && !ctrl.head_clr;
    end else begin : g_mid
      assign nb = q[i+1];
      assign nb_act = q_act[i+1];
    end

    assign din = sel ? ctrl.load_entry : nb;
    assign din_act = sel ? 1'b1 : nb_act;

    ipt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .take   (take),
      .din    (din),
      .din_act(din_act),
      .dout   (q[i]),
      .act    (q_act[i])
    );
  end

  assign head = q[0];
  assign head_act = q_act[0];

endmodule

// ----- rtl/core/instruction_patch_table.sv -----
// A refused apply answers in the cycle after start; codes 6 and 7 give no result.
// Every other request rotates the whole 64-cell ring in the scan state, then answers from the finish state.
// Revert all strobes one result per active entry, or one empty result if none; the last comes from the finish state.
// A refused or ignored request leaves the block idle, taking one request per cycle; any other holds busy to its end.
// Reset (synchronous, active low) clears all active marks and the fill count.
// The receiver cannot stall; each result strobe lasts exactly one cycle.
// ----------------------------------------------------------------------------
// Instruction patch table
// Append-only table of instruction patches with apply, revert and statistics.
// ----------------------------------------------------------------------------
`include "instruction_patch_table_defines.svh"

module instruction_patch_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [63:0] in_target_addr,
  input  logic [63:0] in_branch_target,
  input  logic [31:0] in_new_instr,
  input  logic [31:0] in_current_word,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic        out_write_valid,
  output logic [63:0] out_write_offset,
  output logic [31:0] out_write_data,
  output logic [6:0]  out_active_total,
  output logic [6:0]  out_nop_total,
  output logic [6:0]  out_branch_total,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import ipt_pkg::*;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  func_t func_r, func_nxt;
  logic [63:0] addr_r, addr_nxt;
  logic [63:0] off_r, off_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] cur_r, cur_nxt;
  logic dup_r, dup_nxt;
  logic found_r, found_nxt;
  logic [31:0] orig_r, orig_nxt;
  logic pend_r, pend_nxt;
  logic [63:0] pend_off_r, pend_off_nxt;
  logic [31:0] pend_data_r, pend_data_nxt;
  logic [CNT_W-1:0] pend_tot_r, pend_tot_nxt;
  logic [CNT_W-1:0] act_cnt_r, act_cnt_nxt;
  logic [CNT_W-1:0] nop_cnt_r, nop_cnt_nxt;
  logic [CNT_W-1:0] br_cnt_r, br_cnt_nxt;
  logic enabled_r;
  logic [63:0] base_r;
  logic [63:0] size_r;

  logic out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  logic out_wv_r, out_wv_nxt;
  logic [63:0] out_off_r, out_off_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic [6:0] out_act_r, out_act_nxt;
  logic [6:0] out_nop_r, out_nop_nxt;
  logic [6:0] out_br_r, out_br_nxt;
  logic out_last_r, out_last_nxt;

  chain_ctrl_t ctrl;
  entry_t head;
  logic head_act;
  logic head_hit;

  logic accept;
  logic [63:0] in_off;
  logic [63:0] br_diff;
  logic range_ok;
  logic addr_ok;
  logic [31:0] br_word;

  ipt_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .head    (head),
    .head_act(head_act)
  );

  assign accept = start && !busy;
  assign in_off = in_target_addr - base_r;
  assign br_diff = in_branch_target - in_target_addr;
  assign range_ok = (&br_diff[63:25]) || !(|br_diff[63:25]);
  assign br_word = WORD_B | {6'd0, br_diff[27:2] & IMM26_MASK};
  assign addr_ok = (size_r >= 64'd4) && (in_target_addr >= base_r) &&
                   (in_off < (size_r - 64'd3)) && (in_off[1:0] == 2'b00);
  assign head_hit = head_act && (head.addr == addr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
      base_r <= '0;
      size_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLED: enabled_r <= cfg_data[0];
        CFG_BASE: base_r <= cfg_data;
        CFG_SIZE: size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    addr_r <= addr_nxt;
    off_r <= off_nxt;
    word_r <= word_nxt;
    cur_r <= cur_nxt;
    dup_r <= dup_nxt;
    found_r <= found_nxt;
    orig_r <= orig_nxt;
    pend_r <= pend_nxt;
    pend_off_r <= pend_off_nxt;
    pend_data_r <= pend_data_nxt;
    pend_tot_r <= pend_tot_nxt;
    act_cnt_r <= act_cnt_nxt;
    nop_cnt_r <= nop_cnt_nxt;
    br_cnt_r <= br_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_wv_r <= out_wv_nxt;
    out_off_r <= out_off_nxt;
    out_data_r <= out_data_nxt;
    out_act_r <= out_act_nxt;
    out_nop_r <= out_nop_nxt;
    out_br_r <= out_br_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    count_nxt = count_r;
    func_nxt = func_r;
    addr_nxt = addr_r;
    off_nxt = off_r;
    word_nxt = word_r;
    cur_nxt = cur_r;
    dup_nxt = dup_r;
    found_nxt = found_r;
    orig_nxt = orig_r;
    pend_nxt = pend_r;
    pend_off_nxt = pend_off_r;
    pend_data_nxt = pend_data_r;
    pend_tot_nxt = pend_tot_r;
    act_cnt_nxt = act_cnt_r;
    nop_cnt_nxt = nop_cnt_r;
    br_cnt_nxt = br_cnt_r;
    out_valid_nxt = 1'b0;
    out_status_nxt = STAT_OK;
    out_wv_nxt = 1'b0;
    out_off_nxt = '0;
    out_data_nxt = '0;
    out_act_nxt = '0;
    out_nop_nxt = '0;
    out_br_nxt = '0;
    out_last_nxt = 1'b1;
    ctrl = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt = func_t'(in_func);
          addr_nxt = in_target_addr;
          off_nxt = in_off;
          cur_nxt = in_current_word;
          word_nxt = in_new_instr;
          dup_nxt = 1'b0;
          found_nxt = 1'b0;
          pend_nxt = 1'b0;
          pend_tot_nxt = '0;
          act_cnt_nxt = '0;
          nop_cnt_nxt = '0;
          br_cnt_nxt = '0;
          step_nxt = '0;
          case (func_t'(in_func))
            FUNC_APPLY_WORD, FUNC_APPLY_BRANCH, FUNC_APPLY_NOP: begin
              if (func_t'(in_func) == FUNC_APPLY_BRANCH) begin
                word_nxt = br_word;
              end else if (func_t'(in_func) == FUNC_APPLY_NOP) begin
                word_nxt = WORD_NOP;
              end
              if (func_t'(in_func) == FUNC_APPLY_BRANCH && !range_ok) begin
                out_valid_nxt = 1'b1;
                out_status_nxt = STAT_RANGE;
              end else if (!enabled_r) begin
                out_valid_nxt = 1'b1;
                out_status_nxt = STAT_DISABLED;
              end else if (!addr_ok) begin
                out_valid_nxt = 1'b1;
                out_status_nxt = STAT_BAD_ADDR;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            FUNC_REVERT, FUNC_REVERT_ALL, FUNC_STATS: state_nxt = S_SCAN;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        ctrl.shift = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_FINISH;
        end
        case (func_r)
          FUNC_REVERT: begin
            if (head_hit && !found_r) begin
              found_nxt = 1'b1;
              orig_nxt = head.original;
              ctrl.head_clr = 1'b1;
            end
          end
          FUNC_REVERT_ALL: begin
            if (head_act) begin
              ctrl.head_clr = 1'b1;
              if (pend_r) begin
                out_valid_nxt = 1'b1;
                out_wv_nxt = 1'b1;
                out_off_nxt = pend_off_r;
                out_data_nxt = pend_data_r;
                out_act_nxt = 7'(pend_tot_r);
                out_last_nxt = 1'b0;
              end
              pend_nxt = 1'b1;
              pend_off_nxt = head.addr - base_r;
              pend_data_nxt = head.original;
              pend_tot_nxt = pend_tot_r + 1'b1;
            end
          end
          FUNC_STATS: begin
            if (head_act) begin
              act_cnt_nxt = act_cnt_r + 1'b1;
              if (head.patched == WORD_NOP) begin
                nop_cnt_nxt = nop_cnt_r + 1'b1;
              end else if ((head.patched & OPC_MASK) == WORD_B) begin
                br_cnt_nxt = br_cnt_r + 1'b1;
              end
            end
          end
          default: dup_nxt = dup_r || head_hit;
        endcase
      end
      S_FINISH: begin
        state_nxt = S_IDLE;
        out_valid_nxt = 1'b1;
        case (func_r)
          FUNC_REVERT: begin
            if (found_r) begin
              out_wv_nxt = 1'b1;
              out_off_nxt = off_r;
              out_data_nxt = orig_r;
            end else begin
              out_status_nxt = STAT_NOT_FOUND;
            end
          end
          FUNC_REVERT_ALL: begin
            if (pend_r) begin
              out_wv_nxt = 1'b1;
              out_off_nxt = pend_off_r;
              out_data_nxt = pend_data_r;
              out_act_nxt = 7'(pend_tot_r);
            end
          end
          FUNC_STATS: begin
            out_act_nxt = 7'(act_cnt_r);
            out_nop_nxt = 7'(nop_cnt_r);
            out_br_nxt = 7'(br_cnt_r);
          end
          default: begin
            if (dup_r) begin
              out_status_nxt = STAT_DUPLICATE;
            end else if (count_r >= CNT_W'(TABLE_ENTRIES)) begin
              out_status_nxt = STAT_FULL;
            end else begin
              ctrl.load = 1'b1;
              ctrl.load_idx = count_r[IDX_W-1:0];
              ctrl.load_entry = '{addr: addr_r, original: cur_r, patched: word_r};
              count_nxt = count_r + 1'b1;
              out_wv_nxt = 1'b1;
              out_off_nxt = off_r;
              out_data_nxt = word_r;
            end
          end
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_write_valid = out_wv_r;
  assign out_write_offset = out_off_r;
  assign out_write_data = out_data_r;
  assign out_active_total = out_act_r;
  assign out_nop_total = out_nop_r;
  assign out_branch_total = out_br_r;
  assign out_last = out_last_r;

  `IPT_ASSERT_NEVER(a_count_bound, count_r > CNT_W'(TABLE_ENTRIES), "Fill count too high.")
  `IPT_ASSERT_IMP(a_ring_aligned, state_r == S_FINISH, step_r == '0, "Ring misaligned.")
  `IPT_ASSERT_IMP(a_wr_zero, out_valid_r && !out_wv_r, {out_off_r, out_data_r} == '0, "Stray write.")
  `IPT_ASSERT_IMP(a_idle_still, state_r == S_IDLE, !ctrl.shift && !ctrl.load, "Ring moved.")

endmodule

// ----- verif/tb_instruction_patch_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instruction patch table testbench
// Sends apply, revert, revert-all and stats requests in random bursts and
// through several window settings. A scoreboard predicts every result strobe
// and checks each one field by field.
// ----------------------------------------------------------------------------
module tb_instruction_patch_table;
  import ipt_pkg::*;

  typedef struct {
    logic [2:0]  func;
    logic [63:0] target;
    logic [63:0] dest;
    logic [31:0] word;
    logic [31:0] cur;
  } request_t;

  typedef struct {
    status_t     status;
    logic        wv;
    logic [63:0] offset;
    logic [31:0] data;
    logic [6:0]  act;
    logic [6:0]  nop;
    logic [6:0]  br;
    logic        last;
  } result_t;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 80;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_func;
  logic [63:0] in_target_addr;
  logic [63:0] in_branch_target;
  logic [31:0] in_new_instr;
  logic [31:0] in_current_word;
  logic        out_valid;
  logic [2:0]  out_status;
  logic        out_write_valid;
  logic [63:0] out_write_offset;
  logic [31:0] out_write_data;
  logic [6:0]  out_active_total;
  logic [6:0]  out_nop_total;
  logic [6:0]  out_branch_total;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  instruction_patch_table dut (.*);

  // Shadow copy of the patch table and its registers.
  logic [63:0] tbl_addr [TABLE_ENTRIES];
  logic [31:0] tbl_orig [TABLE_ENTRIES];
  logic [31:0] tbl_patch [TABLE_ENTRIES];
  logic        tbl_active [TABLE_ENTRIES];
  int          tbl_count;
  logic        sh_enabled;
  logic [63:0] sh_base;
  logic [63:0] sh_size;

  request_t pending_requests[$];
  result_t  expected_results[$];
  request_t cur_req;
  int       burst_left;
  int       gap_left;
  int       mismatches;
  int       requests_sent;
  int       results_seen;
  int       cfg_writes;
  int       idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t blank_result(status_t st);
    result_t r;
    r.status = st;
    r.wv = 1'b0;
    r.offset = '0;
    r.data = '0;
    r.act = '0;
    r.nop = '0;
    r.br = '0;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic logic window_hit(logic [63:0] a);
    logic [63:0] off;
    off = a - sh_base;
    if (sh_size < 4) return 1'b0;
    if (a < sh_base) return 1'b0;
    if (off >= sh_size - 3) return 1'b0;
    return off[1:0] == 2'b00;
  endfunction

  function automatic void predict_apply(logic [63:0] a, logic [31:0] w, logic [31:0] orig);
    result_t r;
    if (!sh_enabled) begin
      expected_results.push_back(blank_result(STAT_DISABLED));
      return;
    end
    if (!window_hit(a)) begin
      expected_results.push_back(blank_result(STAT_BAD_ADDR));
      return;
    end
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_active[i] && tbl_addr[i] == a) begin
        expected_results.push_back(blank_result(STAT_DUPLICATE));
        return;
      end
    end
    if (tbl_count >= TABLE_ENTRIES) begin
      expected_results.push_back(blank_result(STAT_FULL));
      return;
    end
    tbl_addr[tbl_count] = a;
    tbl_orig[tbl_count] = orig;
    tbl_patch[tbl_count] = w;
    tbl_active[tbl_count] = 1'b1;
    tbl_count++;
    r = blank_result(STAT_OK);
    r.wv = 1'b1;
    r.offset = a - sh_base;
    r.data = w;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_request(request_t q);
    result_t r;
    logic [63:0] d;
    int k;
    case (q.func)
      FUNC_APPLY_WORD: predict_apply(q.target, q.word, q.cur);
      FUNC_APPLY_BRANCH: begin
        d = q.dest - q.target;
        if (d + 64'h200_0000 >= 64'h400_0000) begin
          expected_results.push_back(blank_result(STAT_RANGE));
        end else begin
          predict_apply(q.target, WORD_B | {6'd0, d[27:2]}, q.cur);
        end
      end
      FUNC_APPLY_NOP: predict_apply(q.target, WORD_NOP, q.cur);
      FUNC_REVERT: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_active[i] && tbl_addr[i] == q.target) begin
            tbl_active[i] = 1'b0;
            r = blank_result(STAT_OK);
            r.wv = 1'b1;
            r.offset = q.target - sh_base;
            r.data = tbl_orig[i];
            expected_results.push_back(r);
            return;
          end
        end
        expected_results.push_back(blank_result(STAT_NOT_FOUND));
      end
      FUNC_REVERT_ALL: begin
        k = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_active[i]) begin
            tbl_active[i] = 1'b0;
            k++;
            r = blank_result(STAT_OK);
            r.wv = 1'b1;
            r.offset = tbl_addr[i] - sh_base;
            r.data = tbl_orig[i];
            r.act = k[6:0];
            r.last = 1'b0;
            expected_results.push_back(r);
          end
        end
        if (k == 0) expected_results.push_back(blank_result(STAT_OK));
        else expected_results[$].last = 1'b1;
      end
      FUNC_STATS: begin
        r = blank_result(STAT_OK);
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_active[i]) begin
            r.act++;
            if (tbl_patch[i] == WORD_NOP) r.nop++;
            else if ((tbl_patch[i] & OPC_MASK) == WORD_B) r.br++;
          end
        end
        expected_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_func <= '0;
      in_target_addr <= '0;
      in_branch_target <= '0;
      in_new_instr <= '0;
      in_current_word <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        predict_request(cur_req);
        requests_sent++;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        cur_req = pending_requests.pop_front();
        in_func <= cur_req.func;
        in_target_addr <= cur_req.target;
        in_branch_target <= cur_req.dest;
        in_new_instr <= cur_req.word;
        in_current_word <= cur_req.cur;
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: status %0d", out_status);
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.status || out_write_valid !== e.wv ||
            out_write_offset !== e.offset || out_write_data !== e.data ||
            out_active_total !== e.act || out_nop_total !== e.nop ||
            out_branch_total !== e.br || out_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch exp st=%0d wv=%0b off=%h dat=%h act=%0d nop=%0d br=%0d last=%0b",
                     e.status, e.wv, e.offset, e.data, e.act, e.nop, e.br, e.last);
            $display("         got st=%0d wv=%0b off=%h dat=%h act=%0d nop=%0d br=%0d last=%0b",
                     out_status, out_write_valid, out_write_offset, out_write_data,
                     out_active_total, out_nop_total, out_branch_total, out_last);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("instruction_patch_table test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic request_t mk(logic [2:0] f, logic [63:0] a, logic [63:0] d,
                                  logic [31:0] w, logic [31:0] c);
    request_t q;
    q.func = f;
    q.target = a;
    q.dest = d;
    q.word = w;
    q.cur = c;
    return q;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_addr();
    case ($urandom_range(0, 19))
      0: return sh_base + sh_size - 4;
      1: return sh_base + 4 * $urandom_range(0, 31) + $urandom_range(1, 3);
      2: return sh_base - 4;
      default: return sh_base + 4 * $urandom_range(0, 31);
    endcase
  endfunction

  task automatic add(request_t q);
    pending_requests.push_back(q);
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_requests.size() > 0 || start || expected_results.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_ENABLED: sh_enabled = val[0];
      CFG_BASE: sh_base = val;
      default: sh_size = val;
    endcase
  endtask

  task automatic set_window(logic en, logic [63:0] b, logic [63:0] s);
    wait_quiet();
    write_reg(CFG_ENABLED, {63'd0, en});
    write_reg(CFG_BASE, b);
    write_reg(CFG_SIZE, s);
  endtask

  task automatic add_random(int n);
    int r;
    logic [63:0] a;
    logic [63:0] d;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      a = pick_addr();
      d = a + {{38{1'b0}}, 26'($urandom)} - 64'h200_0000;
      if ($urandom_range(0, 9) == 0) d = rand64();
      if (r < 28) add(mk(FUNC_APPLY_WORD, a, rand64(), $urandom, $urandom));
      else if (r < 40) add(mk(FUNC_APPLY_BRANCH, a, d, $urandom, $urandom));
      else if (r < 50) add(mk(FUNC_APPLY_NOP, a, rand64(), $urandom, $urandom));
      else if (r < 70) add(mk(FUNC_REVERT, a, rand64(), $urandom, $urandom));
      else if (r < 74) add(mk(FUNC_REVERT_ALL, rand64(), rand64(), $urandom, $urandom));
      else if (r < 84) add(mk(FUNC_STATS, rand64(), rand64(), $urandom, $urandom));
      else if (r < 94) begin
        add(mk(3'($urandom_range(0, 3)), rand64(), rand64(), $urandom, $urandom));
      end else begin
        add(mk(3'($urandom_range(6, 7)), rand64(), rand64(), $urandom, $urandom));
        i--;
      end
    end
  endtask

  initial begin
    logic [63:0] a;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tbl_count = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) tbl_active[i] = 1'b0;
    sh_enabled = 1'b1;
    sh_base = '0;
    sh_size = '0;
    mismatches = 0;
    requests_sent = 0;
    results_seen = 0;
    cfg_writes = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset window is empty, so the apply is refused; the other requests find an empty table.
    add(mk(FUNC_APPLY_WORD, 64'd0, 64'd0, 32'h0, 32'h0));
    add(mk(FUNC_STATS, 64'd0, 64'd0, 32'h0, 32'h0));
    add(mk(FUNC_REVERT_ALL, 64'd0, 64'd0, 32'h0, 32'h0));
    add(mk(FUNC_REVERT, '1, '1, '1, '1));
    add(mk(3'd6, 64'd0, 64'd0, 32'h0, 32'h0));
    add(mk(3'd7, '1, '1, '1, '1));

    set_window(1'b1, 64'h1000, 64'h200);
    a = 64'h1010;
    add(mk(FUNC_APPLY_WORD, 64'h1000, 64'd0, 32'h0, 32'h0));
    add(mk(FUNC_APPLY_WORD, 64'h11FC, 64'd0, '1, '1));
    add(mk(FUNC_APPLY_WORD, 64'h11FD, 64'd0, 32'h1, 32'h2));
    add(mk(FUNC_APPLY_WORD, 64'h0FFC, 64'd0, 32'h1, 32'h2));
    add(mk(FUNC_APPLY_WORD, 64'h1000, 64'd0, 32'h5, 32'h6));
    add(mk(FUNC_APPLY_NOP, 64'h1008, 64'd0, 32'h0, 32'h1234));
    add(mk(FUNC_APPLY_BRANCH, a, a + 64'h1FF_FFFF, 32'h0, 32'h77));
    add(mk(FUNC_APPLY_BRANCH, a + 4, a + 4 - 64'h200_0000, 32'h0, 32'h78));
    add(mk(FUNC_APPLY_BRANCH, a + 8, a + 8 + 64'h200_0000, 32'h0, 32'h79));
    add(mk(FUNC_APPLY_BRANCH, a + 12, a + 12 - 64'h200_0001, 32'h0, 32'h7A));
    add(mk(FUNC_STATS, 64'd0, 64'd0, 32'h0, 32'h0));
    add(mk(FUNC_REVERT, 64'h1000, 64'd0, 32'h0, 32'h0));
    add(mk(FUNC_REVERT, 64'h1000, 64'd0, 32'h0, 32'h0));
    add(mk(FUNC_REVERT_ALL, 64'd0, 64'd0, 32'h0, 32'h0));
    add(mk(FUNC_STATS, 64'd0, 64'd0, 32'h0, 32'h0));
    add_random(60);

    set_window(1'b0, 64'h1000, 64'h200);
    add_random(20);

    set_window(1'b1, 64'hFFFF_FFFF_FFFF_FF00, 64'h100);
    add_random(45);

    set_window(1'b1, 64'd0, '1);
    add_random(45);

    set_window(1'b1, 64'h40, 64'd3);
    add_random(15);

    set_window(1'b1, 64'h2000, 64'h80);
    add_random(30);

    wait_quiet();
    $display("Sent %0d requests and checked %0d result strobes", requests_sent, results_seen);
    $display("Config writes: %0d, table entries used: %0d of %0d",
             cfg_writes, tbl_count, TABLE_ENTRIES);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("instruction_patch_table test passed");
    end else begin
      $display("Mismatches: %0d, results still expected: %0d",
               mismatches, expected_results.size());
      $display("instruction_patch_table test failed");
    end
    $finish;
  end

endmodule
